[rtl/atlas_rect_slice_splitter_assert.svh]
`ifndef ATLAS_RECT_SLICE_SPLITTER_ASSERT_SVH
`define ATLAS_RECT_SLICE_SPLITTER_ASSERT_SVH
// same-cycle implication, held off during reset
`define ARSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, held off during reset
`define ARSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/arss_pkg.sv]
package arss_pkg;
  localparam int SLICE_ROWS = 1024;
  localparam int SLICE_LOG2 = 10;
  localparam int MAX_SLICES = 4;
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] REG_ATLAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SOURCE_SCALE = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

[rtl/arss_div.sv]
module arss_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [arss_pkg::DIV_NUM_W-1:0] num,
  input  logic [arss_pkg::DIV_DEN_W-1:0] den,
  output logic [arss_pkg::DIV_NUM_W-1:0] quo,
  output arss_pkg::div_stat_t stat
);
  import arss_pkg::*;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic done;
  logic [DIV_DEN_W:0] trial;
  logic fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits = trial >= {1'b0, den_q};
  assign stat.busy = cnt != '0;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= num;
        rem <= '0;
        den_q <= den;
        cnt <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt != '0) begin
        quo <= {quo[DIV_NUM_W-2:0], fits};
        rem <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) done <= 1'b1;
      end
    end
  end
endmodule

[rtl/atlas_rect_slice_splitter.sv]
// channel | direction | words
// in      | sink      | one rectangle, corners and colour
// out     | source    | one quad per slice segment, last on the final one
// cfg     | sink      | register index and data, always ready
// Each division runs on the one shared divider (start, 40 steps, result):
// 4 scale divisions, then 8 interpolations per segment, each after a multiply step.
// A new rectangle is taken only in idle, once the last quad has been emitted;
// a rejected rectangle holds in_ready low through its scale divisions and the check.
// Reset clears control and sets the registers to 1024, 1024 and 1.
// A stalled output holds its word; work on the next segment goes on, emit waits.
`include "atlas_rect_slice_splitter_assert.svh"
module atlas_rect_slice_splitter (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] src_x,
  input  logic signed [15:0] src_y,
  input  logic signed [15:0] src_w,
  input  logic signed [15:0] src_h,
  input  logic [47:0] corner_top_left,
  input  logic [47:0] corner_top_right,
  input  logic [47:0] corner_bottom_right,
  input  logic [47:0] corner_bottom_left,
  input  logic [31:0] tint,
  output logic out_valid,
  input  logic out_ready,
  output logic [47:0] seg_top_left,
  output logic [47:0] seg_top_right,
  output logic [47:0] seg_bottom_right,
  output logic [47:0] seg_bottom_left,
  output logic [10:0] tex_col_start,
  output logic [10:0] tex_col_end,
  output logic [10:0] tex_row_start,
  output logic [10:0] tex_row_end,
  output logic [1:0] slice_number,
  output logic [10:0] slice_rows,
  output logic [31:0] seg_tint,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [12:0] cfg_data
);
  import arss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DSTART, ST_DWAIT, ST_CHECK, ST_SEG, ST_MUL, ST_EMIT
  } state_t;

  state_t state;
  logic lerp_phase;
  logic [1:0] div_idx;
  logic [2:0] job;
  logic [10:0] atlas_width;
  logic [12:0] atlas_height;
  logic [3:0] source_scale;
  logic signed [15:0] r_src [4];
  logic [47:0] c_tl, c_tr, c_br, c_bl;
  logic [31:0] r_tint;
  logic signed [16:0] scaled [4];
  logic [10:0] col_start, col_end;
  logic [12:0] my, mh, yc, yend;
  logic [12:0] k0, k1;
  logic [10:0] row_start, row_end, seg_srows;
  logic [1:0] seg_slice;
  logic seg_last;
  logic [1:0] n_seg;
  logic [12:0] next_yc;
  logic signed [41:0] prod;
  logic [23:0] pt_x [4];
  logic [23:0] pt_y [4];

  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic div_start;
  div_stat_t div_stat;

  arss_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .stat(div_stat)
  );

  logic [3:0] scale_eff;
  logic signed [15:0] src_sel;
  logic signed [16:0] src_ext, src_mag, q17, q_signed;
  logic [41:0] prod_mag;
  logic [24:0] q25, delta;
  logic [47:0] pa, pb;
  logic [23:0] a_sel, b_sel;
  logic signed [24:0] diff;
  logic [12:0] k_sel;
  logic [23:0] lerp_res;

  assign scale_eff = (source_scale == '0) ? 4'd1 : source_scale;
  assign src_sel = r_src[div_idx];
  assign src_ext = {src_sel[15], src_sel};
  assign src_mag = src_sel[15] ? 17'sd0 - src_ext : src_ext;
  assign q17 = div_quo[16:0];
  assign q_signed = src_sel[15] ? 17'sd0 - q17 : q17;
  assign prod_mag = prod[41] ? 42'(-prod) : 42'(prod);
  assign q25 = div_quo[24:0];
  assign delta = prod[41] ? 25'd0 - q25 : q25;
  assign lerp_res = a_sel + delta[23:0];

  always_comb begin
    if (lerp_phase) begin
      div_num = DIV_NUM_W'(prod_mag) + DIV_NUM_W'(mh >> 1);
      div_den = DIV_DEN_W'(mh);
    end else begin
      div_num = DIV_NUM_W'(unsigned'(src_mag));
      div_den = DIV_DEN_W'(scale_eff);
    end
  end

  always_comb begin
    case (job[2:1])
      2'd0, 2'd3: begin
        pa = c_tl;
        pb = c_bl;
      end
      default: begin
        pa = c_tr;
        pb = c_br;
      end
    endcase
    a_sel = job[0] ? pa[23:0] : pa[47:24];
    b_sel = job[0] ? pb[23:0] : pb[47:24];
    k_sel = job[2] ? k1 : k0;
  end
  assign diff = 25'($signed(b_sel)) - 25'($signed(a_sel));
  assign div_start = state == ST_DSTART;

  logic signed [16:0] mx_s, my_s, mw_s, mh_s;
  logic signed [17:0] x_end, y_end;
  logic reject;

  always_comb begin
    mx_s = scaled[0];
    my_s = scaled[1];
    mw_s = scaled[2];
    mh_s = scaled[3];
    if (mw_s <= 0 && r_src[2] > 0) mw_s = 17'sd1;
    if (mh_s <= 0 && r_src[3] > 0) mh_s = 17'sd1;
    x_end = 18'(mx_s) + 18'(mw_s);
    y_end = 18'(my_s) + 18'(mh_s);
    reject = mw_s <= 0 || mh_s <= 0 || mx_s < 0 || my_s < 0
          || x_end > $signed({7'd0, atlas_width})
          || y_end > $signed({5'd0, atlas_height});
  end

  logic [12:0] sy, srows, send, seg_end;
  logic [2:0] si, nslices, next_si;
  logic [13:0] nsl_raw;

  always_comb begin
    si = yc[12:SLICE_LOG2];
    sy = 13'(si) << SLICE_LOG2;
    srows = atlas_height - sy;
    if (srows > 13'(SLICE_ROWS)) srows = 13'(SLICE_ROWS);
    send = sy + srows;
    seg_end = (yend < send) ? yend : send;
    next_si = seg_end[12:SLICE_LOG2];
    nsl_raw = (14'(atlas_height) + 14'(SLICE_ROWS - 1)) >> SLICE_LOG2;
    nslices = (nsl_raw > 14'(MAX_SLICES)) ? 3'(MAX_SLICES) : nsl_raw[2:0];
  end

  assign in_ready = state == ST_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      atlas_width <= 11'd1024;
      atlas_height <= 13'd1024;
      source_scale <= 4'd1;
      lerp_phase <= 1'b0;
      div_idx <= '0;
      job <= '0;
      n_seg <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ATLAS_WIDTH: atlas_width <= cfg_data[10:0];
          REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
          REG_SOURCE_SCALE: source_scale <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r_src[0] <= src_x;
            r_src[1] <= src_y;
            r_src[2] <= src_w;
            r_src[3] <= src_h;
            c_tl <= corner_top_left;
            c_tr <= corner_top_right;
            c_br <= corner_bottom_right;
            c_bl <= corner_bottom_left;
            r_tint <= tint;
            lerp_phase <= 1'b0;
            div_idx <= '0;
            state <= ST_DSTART;
          end
        end
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_stat.done) begin
            if (lerp_phase) begin
              if (job[0]) pt_y[job[2:1]] <= lerp_res;
              else pt_x[job[2:1]] <= lerp_res;
              job <= job + 1'b1;
              state <= (job == 3'd7) ? ST_EMIT : ST_MUL;
            end else begin
              scaled[div_idx] <= q_signed;
              div_idx <= div_idx + 1'b1;
              state <= (div_idx == 2'd3) ? ST_CHECK : ST_DSTART;
            end
          end
        end
        ST_CHECK: begin
          if (reject || my_s[12:SLICE_LOG2] >= nslices) begin
            state <= ST_IDLE;
          end else begin
            col_start <= mx_s[10:0];
            col_end <= x_end[10:0];
            my <= my_s[12:0];
            mh <= mh_s[12:0];
            yc <= my_s[12:0];
            yend <= y_end[12:0];
            n_seg <= '0;
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          k0 <= yc - my;
          k1 <= seg_end - my;
          row_start <= 11'(yc - sy);
          row_end <= 11'(seg_end - sy);
          seg_srows <= srows[10:0];
          seg_slice <= si[1:0];
          seg_last <= seg_end >= yend || n_seg == 2'(MAX_SLICES - 1)
                   || next_si >= nslices;
          next_yc <= seg_end;
          lerp_phase <= 1'b1;
          job <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod <= 42'(diff) * $signed({4'd0, k_sel});
          state <= ST_DSTART;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            seg_top_left <= {pt_x[0], pt_y[0]};
            seg_top_right <= {pt_x[1], pt_y[1]};
            seg_bottom_right <= {pt_x[2], pt_y[2]};
            seg_bottom_left <= {pt_x[3], pt_y[3]};
            tex_col_start <= col_start;
            tex_col_end <= col_end;
            tex_row_start <= row_start;
            tex_row_end <= row_end;
            slice_number <= seg_slice;
            slice_rows <= seg_srows;
            seg_tint <= r_tint;
            last <= seg_last;
            if (seg_last) begin
              state <= ST_IDLE;
            end else begin
              yc <= next_yc;
              n_seg <= n_seg + 1'b1;
              state <= ST_SEG;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ARSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `ARSS_ASSERT_NOW(a_div_done_waited, div_stat.done, state == ST_DWAIT, "stray divider result")
  `ARSS_ASSERT_NOW(a_div_busy_waited, div_stat.busy, state == ST_DWAIT, "divider busy out of wait")
endmodule
